FILE: design/tmsd_pkg.sv
// ----------------------------------------------------------------------------
// tmsd_pkg
// shared types and constants for the midpoint subdivide and displace unit
// ----------------------------------------------------------------------------
package tmsd_pkg;

  localparam int unsigned CoordBits = 24;

  typedef enum logic [1:0] {
    REG_HIT_RADIUS    = 2'd0,
    REG_DISPLACE_STEP = 2'd1,
    REG_MIDPOINT_LIFT = 2'd2,
    REG_ACTIVE_POINTS = 2'd3
  } reg_index_t;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TRI  = 1'b1;

  typedef struct packed {
    logic                        kind;
    logic [3:0]                  point_slot;
    logic signed [CoordBits-1:0] ax;
    logic signed [CoordBits-1:0] ay;
    logic signed [CoordBits-1:0] az;
    logic signed [CoordBits-1:0] bx;
    logic signed [CoordBits-1:0] by;
    logic signed [CoordBits-1:0] bz;
    logic signed [CoordBits-1:0] cx;
    logic signed [CoordBits-1:0] cy;
    logic signed [CoordBits-1:0] cz;
  } in_beat_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] out_x;
    logic signed [CoordBits-1:0] out_y;
    logic signed [CoordBits-1:0] out_z;
    logic                        last_vertex;
  } out_beat_t;

  typedef struct packed {
    logic [22:0]                 hit_radius;
    logic signed [CoordBits-1:0] displace_step;
    logic signed [CoordBits-1:0] midpoint_lift;
    logic [4:0]                  active_points;
  } cfg_regs_t;

  // emission order of the twelve vertex beats over the six vertices (a b c ab bc ca)
  function automatic logic [2:0] emit_sel(input logic [3:0] j);
    case (j)
      4'd0:    emit_sel = 3'd0;
      4'd1:    emit_sel = 3'd3;
      4'd2:    emit_sel = 3'd5;
      4'd3:    emit_sel = 3'd5;
      4'd4:    emit_sel = 3'd4;
      4'd5:    emit_sel = 3'd2;
      4'd6:    emit_sel = 3'd3;
      4'd7:    emit_sel = 3'd1;
      4'd8:    emit_sel = 3'd4;
      4'd9:    emit_sel = 3'd3;
      4'd10:   emit_sel = 3'd4;
      4'd11:   emit_sel = 3'd5;
      default: emit_sel = 3'd0;
    endcase
  endfunction

endpackage

FILE: design/tmsd_ram.sv
// ----------------------------------------------------------------------------
// tmsd_ram
// generic single-port write, single read port ram with registered read
// ----------------------------------------------------------------------------
module tmsd_ram #(
  parameter  int unsigned WIDTH = 72,
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/tmsd_hit.sv
// ----------------------------------------------------------------------------
// tmsd_hit
// registered distance test of one vertex against one table point
// ----------------------------------------------------------------------------
module tmsd_hit
  import tmsd_pkg::*;
#(
  parameter int unsigned CB = 24
) (
  input  logic                 clk,
  input  logic signed [CB-1:0] vx,
  input  logic signed [CB-1:0] vy,
  input  logic signed [CB-1:0] vz,
  input  logic signed [CB-1:0] px,
  input  logic signed [CB-1:0] py,
  input  logic signed [CB-1:0] pz,
  input  logic [22:0]          radius,
  output logic                 hit
);

  logic signed [CB:0] dx, dy, dz;
  logic [CB:0]        ax, ay, az;
  logic               near_axes;
  logic [22:0]        sx, sy, sz;
  logic [45:0]        qx, qy, qz, rr;
  logic [47:0]        sum;

  always_comb begin
    dx = {vx[CB-1], vx} - {px[CB-1], px};
    dy = {vy[CB-1], vy} - {py[CB-1], py};
    dz = {vz[CB-1], vz} - {pz[CB-1], pz};
    ax = dx[CB] ? (CB+1)'(-dx) : dx;
    ay = dy[CB] ? (CB+1)'(-dy) : dy;
    az = dz[CB] ? (CB+1)'(-dz) : dz;
    near_axes = (ax < (CB+1)'(radius)) && (ay < (CB+1)'(radius)) && (az < (CB+1)'(radius));
    sx = ax[22:0];
    sy = ay[22:0];
    sz = az[22:0];
  end

  // stage 1: squares, stage 2: sum and compare
  logic        near_q;
  always_ff @(posedge clk) begin
    qx     <= sx * sx;
    qy     <= sy * sy;
    qz     <= sz * sz;
    rr     <= radius * radius;
    near_q <= near_axes;
  end

  assign sum = 48'(qx) + 48'(qy) + 48'(qz);
  assign hit = near_q && (sum < 48'(rr));

endmodule

FILE: design/tmsd_core.sv
// ----------------------------------------------------------------------------
// tmsd_core
// sequencer: midpoints, point sweep through the table ram, emission
// ----------------------------------------------------------------------------
module tmsd_core
  import tmsd_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 16,
  parameter int unsigned CB         = 24
) (
  input  logic      clk,
  input  logic      rst,
  input  in_beat_t  in_beat,
  input  logic      in_valid,
  output logic      in_ready,
  input  cfg_regs_t regs,
  output out_beat_t out_beat,
  output logic      out_valid,
  input  logic      out_ready
);

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

  typedef enum logic [2:0] {S_IDLE, S_READ, S_TEST, S_APPLY, S_LIFT, S_EMIT} state_t;

  state_t               state;
  logic signed [CB-1:0] vx [6];
  logic signed [CB-1:0] vy [6];
  logic signed [CB-1:0] vz [6];
  logic [CW-1:0]        n_pts;
  logic [CW-1:0]        idx;
  logic [3:0]           emit_idx;

  function automatic logic signed [CB-1:0] sat_add(input logic signed [CB-1:0] a,
                                                  input logic signed [CB-1:0] b);
    logic signed [CB:0] s;
    s = {a[CB-1], a} + {b[CB-1], b};
    if (s > $signed({1'b0, CMAX})) sat_add = CMAX;
    else if (s < $signed({1'b1, CMIN})) sat_add = CMIN;
    else sat_add = s[CB-1:0];
  endfunction

  function automatic logic signed [CB-1:0] mid(input logic signed [CB-1:0] a,
                                              input logic signed [CB-1:0] b);
    logic signed [CB:0] s;
    s = {a[CB-1], a} + {b[CB-1], b};
    mid = s[CB:1];
  endfunction

  // point table
  logic                 we;
  logic [3*CB-1:0]      rdata;
  logic signed [CB-1:0] px, py, pz;

  assign we = in_valid && in_ready && (in_beat.kind == KIND_LOAD)
              && (32'(in_beat.point_slot) < MAX_POINTS);

  tmsd_ram #(.WIDTH(3*CB), .DEPTH(MAX_POINTS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(in_beat.point_slot)),
    .wdata ({in_beat.ax[CB-1:0], in_beat.ay[CB-1:0], in_beat.az[CB-1:0]}),
    .raddr (idx[AW-1:0]),
    .rdata (rdata)
  );

  assign px = rdata[3*CB-1:2*CB];
  assign py = rdata[2*CB-1:CB];
  assign pz = rdata[CB-1:0];

  logic [5:0] hit_w;
  for (genvar k = 0; k < 6; k++) begin : g_hit
    tmsd_hit #(.CB(CB)) u_hit (
      .clk (clk), .vx (vx[k]), .vy (vy[k]), .vz (vz[k]),
      .px (px), .py (py), .pz (pz), .radius (regs.hit_radius), .hit (hit_w[k])
    );
  end

  assign in_ready = (state == S_IDLE);

  logic [2:0] sel;
  assign sel = emit_sel(emit_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      idx       <= '0;
      emit_idx  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && in_beat.kind == KIND_TRI) begin
            vx[0] <= in_beat.ax[CB-1:0]; vy[0] <= in_beat.ay[CB-1:0];
            vz[0] <= in_beat.az[CB-1:0];
            vx[1] <= in_beat.bx[CB-1:0]; vy[1] <= in_beat.by[CB-1:0];
            vz[1] <= in_beat.bz[CB-1:0];
            vx[2] <= in_beat.cx[CB-1:0]; vy[2] <= in_beat.cy[CB-1:0];
            vz[2] <= in_beat.cz[CB-1:0];
            vx[3] <= mid(in_beat.ax[CB-1:0], in_beat.bx[CB-1:0]);
            vy[3] <= mid(in_beat.ay[CB-1:0], in_beat.by[CB-1:0]);
            vz[3] <= mid(in_beat.az[CB-1:0], in_beat.bz[CB-1:0]);
            vx[4] <= mid(in_beat.bx[CB-1:0], in_beat.cx[CB-1:0]);
            vy[4] <= mid(in_beat.by[CB-1:0], in_beat.cy[CB-1:0]);
            vz[4] <= mid(in_beat.bz[CB-1:0], in_beat.cz[CB-1:0]);
            vx[5] <= mid(in_beat.cx[CB-1:0], in_beat.ax[CB-1:0]);
            vy[5] <= mid(in_beat.cy[CB-1:0], in_beat.ay[CB-1:0]);
            vz[5] <= mid(in_beat.cz[CB-1:0], in_beat.az[CB-1:0]);
            n_pts <= (32'(regs.active_points) > MAX_POINTS) ? CW'(MAX_POINTS)
                                                             : CW'(regs.active_points);
            idx   <= '0;
            state <= S_READ;
          end
        end
        S_READ: begin
          if (idx >= n_pts) state <= S_LIFT;
          else state <= S_TEST;
        end
        S_TEST: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          for (int k = 0; k < 6; k++) begin
            if (hit_w[k]) vz[k] <= sat_add(vz[k], regs.displace_step);
          end
          idx   <= idx + 1'b1;
          state <= S_READ;
        end
        S_LIFT: begin
          for (int k = 3; k < 6; k++) vz[k] <= sat_add(vz[k], regs.midpoint_lift);
          emit_idx <= '0;
          state    <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            if (out_valid && out_beat.last_vertex) begin
              out_valid <= 1'b0;
              state     <= S_IDLE;
            end else begin
              out_beat.out_x       <= vx[sel];
              out_beat.out_y       <= vy[sel];
              out_beat.out_z       <= vz[sel];
              out_beat.last_vertex <= (emit_idx == 4'd11);
              out_valid            <= 1'b1;
              emit_idx             <= emit_idx + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/triangle_midpoint_subdivide_displace_unit.sv
// ----------------------------------------------------------------------------
// triangle_midpoint_subdivide_displace_unit
// splits a triangle into four at its edge midpoints and raises vertices near
// stored displacement points
// ----------------------------------------------------------------------------
// A point load beat is written to the table ram as it is accepted. A triangle
// beat runs, per active point, a table ram read, a squaring stage and a z
// update, then setup and lift, then twelve vertex beats at one per cycle when
// the sink is ready, and a closing step back to idle.
module triangle_midpoint_subdivide_displace_unit
  import tmsd_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_beat_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  cfg_regs_t regs;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_HIT_RADIUS:    regs.hit_radius    <= cfg_data[22:0];
        REG_DISPLACE_STEP: regs.displace_step <= cfg_data;
        REG_MIDPOINT_LIFT: regs.midpoint_lift <= cfg_data;
        REG_ACTIVE_POINTS: regs.active_points <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  tmsd_core #(.MAX_POINTS(MAX_POINTS), .CB(CoordBits)) u_core (
    .clk       (clk),
    .rst       (rst),
    .in_beat   (in_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .regs      (regs),
    .out_beat  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule

FILE: bench/tb_triangle_midpoint_subdivide_displace_unit.sv
// ----------------------------------------------------------------------------
// tb_triangle_midpoint_subdivide_displace_unit
// Self-checking bench for the midpoint subdivide and displace unit. Point
// loads and triangles are driven from a queue with random gaps. A behavioural
// predictor computes the twelve vertices of every triangle, and a monitor
// with random back-pressure compares each output beat with the oldest one.
// The run passes through several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_triangle_midpoint_subdivide_displace_unit;
  import tmsd_pkg::*;

  localparam int NumPoints = 16;
  localparam longint CoordMax = 64'sd8388607;
  localparam longint CoordMin = -64'sd8388608;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_beat_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_beat_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;

  triangle_midpoint_subdivide_displace_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  longint    pt_x [NumPoints];
  longint    pt_y [NumPoints];
  longint    pt_z [NumPoints];
  longint    radius;
  longint    step;
  longint    lift;
  int        n_active;

  in_beat_t  beat_queue[$];
  out_beat_t vertex_queue[$];
  int        errors;
  int        tri_count;
  int        vertex_count;
  int        in_gap;
  int        out_gap;
  int        in_draw;
  int        out_draw;

  logic signed [23:0] pt_seed_x [NumPoints];
  logic signed [23:0] pt_seed_y [NumPoints];
  logic signed [23:0] pt_seed_z [NumPoints];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200000000;
    $display("tb_triangle_midpoint_subdivide_displace_unit: errors");
    $finish;
  end

  function automatic longint sat24(input longint v);
    if (v > CoordMax) return CoordMax;
    if (v < CoordMin) return CoordMin;
    return v;
  endfunction

  function automatic bit is_near(input longint vx, vy, vz, input int p);
    longint dx, dy, dz;
    dx = vx - pt_x[p]; if (dx < 0) dx = -dx;
    dy = vy - pt_y[p]; if (dy < 0) dy = -dy;
    dz = vz - pt_z[p]; if (dz < 0) dz = -dz;
    if (dx >= radius || dy >= radius || dz >= radius) return 1'b0;
    return dx * dx + dy * dy + dz * dz < radius * radius;
  endfunction

  // updates the table on a load, or queues the twelve vertices of a triangle
  task automatic predict_beat(input in_beat_t b);
    longint vx [6];
    longint vy [6];
    longint vz [6];
    int     sel [12];
    out_beat_t o;
    int n;
    sel = '{0, 3, 5, 5, 4, 2, 3, 1, 4, 3, 4, 5};
    if (b.kind == KIND_LOAD) begin
      pt_x[b.point_slot] = b.ax;
      pt_y[b.point_slot] = b.ay;
      pt_z[b.point_slot] = b.az;
      return;
    end
    vx[0] = b.ax; vy[0] = b.ay; vz[0] = b.az;
    vx[1] = b.bx; vy[1] = b.by; vz[1] = b.bz;
    vx[2] = b.cx; vy[2] = b.cy; vz[2] = b.cz;
    vx[3] = (vx[0] + vx[1]) >>> 1; vy[3] = (vy[0] + vy[1]) >>> 1;
    vz[3] = (vz[0] + vz[1]) >>> 1;
    vx[4] = (vx[1] + vx[2]) >>> 1; vy[4] = (vy[1] + vy[2]) >>> 1;
    vz[4] = (vz[1] + vz[2]) >>> 1;
    vx[5] = (vx[2] + vx[0]) >>> 1; vy[5] = (vy[2] + vy[0]) >>> 1;
    vz[5] = (vz[2] + vz[0]) >>> 1;
    n = n_active > NumPoints ? NumPoints : n_active;
    for (int p = 0; p < n; p++)
      for (int k = 0; k < 6; k++)
        if (is_near(vx[k], vy[k], vz[k], p)) vz[k] = sat24(vz[k] + step);
    for (int k = 3; k < 6; k++) vz[k] = sat24(vz[k] + lift);
    for (int j = 0; j < 12; j++) begin
      o.out_x = vx[sel[j]][23:0];
      o.out_y = vy[sel[j]][23:0];
      o.out_z = vz[sel[j]][23:0];
      o.last_vertex = (j == 11);
      vertex_queue.push_back(o);
    end
    tri_count++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else if (in_valid && !in_ready) begin
    end else if (in_valid && in_ready) begin
      in_draw = $urandom_range(0, 15);
      if (in_draw == 0 && beat_queue.size() > 0) begin
        in_data <= beat_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
        in_gap   <= (in_draw > 0) ? in_draw - 1 : 0;
      end
    end else if (in_gap > 0) begin
      in_gap <= in_gap - 1;
    end else if (beat_queue.size() > 0) begin
      in_data  <= beat_queue.pop_front();
      in_valid <= 1'b1;
    end
  end

  always @(posedge clk)
    if (!rst && in_valid && in_ready) predict_beat(in_data);

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_gap   <= 0;
    end else begin
      if (out_valid && out_ready) begin
        vertex_count++;
        if (vertex_queue.size() == 0) begin
          $error("unexpected vertex beat x=%0d", $signed(out_data.out_x));
          errors++;
        end else begin
          out_beat_t e;
          e = vertex_queue.pop_front();
          if (out_data.out_x !== e.out_x) begin
            $error("out_x exp %0d got %0d", e.out_x, out_data.out_x); errors++;
          end
          if (out_data.out_y !== e.out_y) begin
            $error("out_y exp %0d got %0d", e.out_y, out_data.out_y); errors++;
          end
          if (out_data.out_z !== e.out_z) begin
            $error("out_z exp %0d got %0d", e.out_z, out_data.out_z); errors++;
          end
          if (out_data.last_vertex !== e.last_vertex) begin
            $error("last_vertex exp %0b got %0b", e.last_vertex, out_data.last_vertex);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap   <= out_gap - 1;
        out_ready <= 1'b0;
      end else if (out_ready && out_valid) begin
        out_draw = $urandom_range(0, 15);
        out_gap   <= (out_draw > 0) ? out_draw - 1 : 0;
        out_ready <= (out_draw == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input reg_index_t idx, input logic [23:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_HIT_RADIUS:    radius = val[22:0];
      REG_DISPLACE_STEP: step = $signed(val);
      REG_MIDPOINT_LIFT: lift = $signed(val);
      REG_ACTIVE_POINTS: n_active = val[4:0];
      default: ;
    endcase
  endtask

  task automatic setup(input logic [23:0] r, s, l, input logic [4:0] n);
    write_reg(REG_HIT_RADIUS, r);
    write_reg(REG_DISPLACE_STEP, s);
    write_reg(REG_MIDPOINT_LIFT, l);
    write_reg(REG_ACTIVE_POINTS, {19'd0, n});
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while ((beat_queue.size() > 0 || in_valid || vertex_queue.size() > 0)
           && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [23:0] rnd_coord(input int span);
    case ($urandom_range(0, 5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom());
      default: return 24'($urandom_range(0, 2 * span) - span);
    endcase
  endfunction

  task automatic push_load(input int slot, input logic [23:0] x, y, z);
    in_beat_t b;
    b = in_beat_t'(($bits(in_beat_t))'($urandom()));
    b.kind = KIND_LOAD; b.point_slot = 4'(slot); b.ax = x; b.ay = y; b.az = z;
    beat_queue.push_back(b);
  endtask

  task automatic push_tri(input in_beat_t b);
    b.kind = KIND_TRI;
    beat_queue.push_back(b);
  endtask

  // triangle clustered around a table point so that hits occur
  task automatic push_near_tri(input int span);
    in_beat_t b;
    int p;
    p = $urandom_range(0, NumPoints - 1);
    b = in_beat_t'(($bits(in_beat_t))'($urandom()));
    b.point_slot = 4'($urandom());
    b.ax = pt_seed_x[p] + $signed(24'($urandom_range(0, 2 * span) - span));
    b.ay = pt_seed_y[p] + $signed(24'($urandom_range(0, 2 * span) - span));
    b.az = pt_seed_z[p] + $signed(24'($urandom_range(0, 2 * span) - span));
    b.bx = pt_seed_x[p] + $signed(24'($urandom_range(0, 2 * span) - span));
    b.by = pt_seed_y[p] + $signed(24'($urandom_range(0, 2 * span) - span));
    b.bz = pt_seed_z[p] + $signed(24'($urandom_range(0, 2 * span) - span));
    b.cx = pt_seed_x[p] + $signed(24'($urandom_range(0, 2 * span) - span));
    b.cy = pt_seed_y[p] + $signed(24'($urandom_range(0, 2 * span) - span));
    b.cz = pt_seed_z[p] + $signed(24'($urandom_range(0, 2 * span) - span));
    push_tri(b);
  endtask

  initial begin
    in_beat_t b;
    errors = 0; tri_count = 0; vertex_count = 0;
    radius = 0; step = 0; lift = 0; n_active = 0;
    for (int i = 0; i < NumPoints; i++) begin
      pt_x[i] = 0; pt_y[i] = 0; pt_z[i] = 0;
    end
    cfg_valid = 1'b0; cfg_index = REG_HIT_RADIUS; cfg_data = '0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // triangles with no active points, reset registers
    b = '0; b.ax = 24'h7FFFFF; b.ay = 24'h7FFFFF; b.az = 24'h7FFFFF;
    b.bx = 24'h7FFFFF; b.by = 24'h7FFFFF; b.bz = 24'h7FFFFF;
    b.cx = 24'h800000; b.cy = 24'h800000; b.cz = 24'h800000;
    push_tri(b);
    b.ax = 24'h800000; b.bx = 24'h800001; b.cx = 24'h000001; push_tri(b);
    drain();

    // fill every slot, extremes first
    for (int i = 0; i < NumPoints; i++) begin
      pt_seed_x[i] = (i == 0) ? 24'sh7FFFFF : (i == 1) ? 24'sh800000 : 24'($urandom());
      pt_seed_y[i] = (i == 0) ? 24'sh7FFFFF : (i == 1) ? 24'sh800000 : 24'($urandom());
      pt_seed_z[i] = (i == 0) ? 24'sh7FFFFF : (i == 1) ? 24'sh800000 : 24'($urandom());
      push_load(i, pt_seed_x[i], pt_seed_y[i], pt_seed_z[i]);
    end
    drain();

    // zero radius with all points active
    setup(24'd0, 24'h7FFFFF, 24'h000100, 5'd16);
    push_near_tri(4);
    drain();

    // largest radius, saturating step and lift, active count above the table
    setup(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 5'd31);
    push_near_tri(16);
    b = '0; b.az = 24'h7FFFFF; b.bz = 24'h7FFFFF; b.cz = 24'h7FFFFF; push_tri(b);
    drain();
    setup(24'h7FFFFF, 24'h800000, 24'h800000, 5'd16);
    b = '0; b.az = 24'h800000; b.bz = 24'h800000; b.cz = 24'h800000; push_tri(b);
    push_near_tri(16);
    drain();

    // random phases; points reloaded with random content
    for (int ph = 0; ph < 6; ph++) begin
      setup(ph == 5 ? 24'd1 : 24'($urandom_range(1, 4096)), rnd_coord(2048),
            rnd_coord(2048), 5'($urandom_range(0, 31)));
      for (int it = 0; it < 40; it++) begin
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
          int s;
          s = $urandom_range(0, NumPoints - 1);
          pt_seed_x[s] = 24'($urandom());
          pt_seed_y[s] = 24'($urandom());
          pt_seed_z[s] = 24'($urandom());
          push_load(s, pt_seed_x[s], pt_seed_y[s], pt_seed_z[s]);
        end else if (r < 8) begin
          push_near_tri(ph == 5 ? 2 : 3000);
        end else begin
          b = in_beat_t'(($bits(in_beat_t))'($urandom()));
          b.ax = rnd_coord(1 << 20); b.ay = rnd_coord(1 << 20); b.az = rnd_coord(1 << 20);
          b.bx = rnd_coord(1 << 20); b.by = rnd_coord(1 << 20); b.bz = rnd_coord(1 << 20);
          b.cx = rnd_coord(1 << 20); b.cy = rnd_coord(1 << 20); b.cz = rnd_coord(1 << 20);
          push_tri(b);
        end
      end
      drain();
    end

    if (in_valid || beat_queue.size() > 0 || vertex_queue.size() > 0) begin
      $error("stimulus or expected vertices left over");
      errors++;
    end
    $display("run covered %0d triangles and %0d vertex beats over ten register settings",
             tri_count, vertex_count);
    if (errors == 0)
      $display("tb_triangle_midpoint_subdivide_displace_unit: clean");
    else
      $display("tb_triangle_midpoint_subdivide_displace_unit: errors");
    $finish;
  end

endmodule
